### hw/rtl/arbb_pkg.sv
// shared types and constants for the affine rectangle bounding box block
`timescale 1ns / 1ps

package arbb_pkg;

    // fixed-point layout
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int SHIFT_W   = PROD_W - FRAC_BITS;
    localparam int SUM_W     = SHIFT_W + 2;
    localparam int SPAN_W    = COORD_W - 1;

    // configuration register indexes
    localparam logic [2:0] REG_COEF_XX  = 3'd0;
    localparam logic [2:0] REG_COEF_XY  = 3'd1;
    localparam logic [2:0] REG_OFFSET_X = 3'd2;
    localparam logic [2:0] REG_COEF_YX  = 3'd3;
    localparam logic [2:0] REG_COEF_YY  = 3'd4;
    localparam logic [2:0] REG_OFFSET_Y = 3'd5;

    // reset matrix is the identity
    localparam logic signed [COORD_W-1:0] COEF_ONE  = COORD_W'(1 << FRAC_BITS);
    localparam logic signed [COORD_W-1:0] COEF_ZERO = '0;

    typedef logic signed [COORD_W-1:0] coord_t;

    // affine matrix held in the configuration registers
    typedef struct packed {
        coord_t coef_xx;
        coord_t coef_xy;
        coord_t offset_x;
        coord_t coef_yx;
        coord_t coef_yy;
        coord_t offset_y;
    } affine_t;

    // rectangle corners after the first stage
    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
        logic   clip;
    } corner_t;

    // mapped corners after the sum stage
    typedef struct packed {
        coord_t [3:0] px;
        coord_t [3:0] py;
        logic         clip;
    } mapped_t;

    // per-stage load enables of the pipeline
    typedef struct packed {
        logic corner;
        logic mult;
        logic sum;
        logic minmax;
        logic span;
    } pipe_en_t;

endpackage

### hw/rtl/arbb_corner.sv
// stage one: far corner of the rectangle with saturation
`timescale 1ns / 1ps

module arbb_corner
    import arbb_pkg::*;
(
    input  logic     aclk,
    input  pipe_en_t pipe_en,
    input  coord_t   rect_x,
    input  coord_t   rect_y,
    input  coord_t   rect_w,
    input  coord_t   rect_h,
    output corner_t  corner
);

    logic signed [COORD_W:0] sum_x;
    logic signed [COORD_W:0] sum_y;
    logic                    ovf_x;
    logic                    ovf_y;
    corner_t                 corner_next;
    corner_t                 corner_reg;

    // widened sums, overflow when the top two bits differ
    assign sum_x = (COORD_W+1)'(rect_x) + (COORD_W+1)'(rect_w);
    assign sum_y = (COORD_W+1)'(rect_y) + (COORD_W+1)'(rect_h);
    assign ovf_x = sum_x[COORD_W] ^ sum_x[COORD_W-1];
    assign ovf_y = sum_y[COORD_W] ^ sum_y[COORD_W-1];

    always_comb begin
        corner_next.x0   = rect_x;
        corner_next.y0   = rect_y;
        corner_next.x1   = ovf_x ? {sum_x[COORD_W], {(COORD_W-1){~sum_x[COORD_W]}}}
                                 : sum_x[COORD_W-1:0];
        corner_next.y1   = ovf_y ? {sum_y[COORD_W], {(COORD_W-1){~sum_y[COORD_W]}}}
                                 : sum_y[COORD_W-1:0];
        corner_next.clip = ovf_x | ovf_y;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en.corner) begin
            corner_reg <= corner_next;
        end
    end

    assign corner = corner_reg;

endmodule

### hw/rtl/arbb_map.sv
// stages two and three: coefficient products, then mapped corner sums
`timescale 1ns / 1ps

module arbb_map
    import arbb_pkg::*;
(
    input  logic     aclk,
    input  pipe_en_t pipe_en,
    input  affine_t  mat,
    input  corner_t  corner,
    output mapped_t  mapped
);

    logic signed [PROD_W-1:0]  prod_ax [2];
    logic signed [PROD_W-1:0]  prod_by [2];
    logic signed [PROD_W-1:0]  prod_cx [2];
    logic signed [PROD_W-1:0]  prod_dy [2];
    logic signed [SHIFT_W-1:0] ax_reg [2];
    logic signed [SHIFT_W-1:0] by_reg [2];
    logic signed [SHIFT_W-1:0] cx_reg [2];
    logic signed [SHIFT_W-1:0] dy_reg [2];
    logic                      clip1_reg;
    logic signed [SUM_W-1:0]   sum_px [4];
    logic signed [SUM_W-1:0]   sum_py [4];
    logic [3:0]                ovf_px;
    logic [3:0]                ovf_py;
    mapped_t                   mapped_next;
    mapped_t                   mapped_reg;

    // saturate a wide sum to the 32-bit signed range
    function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
        logic ovf;
        ovf = (v[SUM_W-1:COORD_W-1] != {(SUM_W-COORD_W+1){v[SUM_W-1]}});
        if (ovf) begin
            sat_coord = {v[SUM_W-1], {(COORD_W-1){~v[SUM_W-1]}}};
        end else begin
            sat_coord = v[COORD_W-1:0];
        end
    endfunction

    function automatic logic sat_flag(input logic signed [SUM_W-1:0] v);
        sat_flag = (v[SUM_W-1:COORD_W-1] != {(SUM_W-COORD_W+1){v[SUM_W-1]}});
    endfunction

    // eight multipliers, one per coefficient and edge coordinate
    always_comb begin
        prod_ax[0] = PROD_W'(mat.coef_xx) * PROD_W'(corner.x0);
        prod_ax[1] = PROD_W'(mat.coef_xx) * PROD_W'(corner.x1);
        prod_by[0] = PROD_W'(mat.coef_xy) * PROD_W'(corner.y0);
        prod_by[1] = PROD_W'(mat.coef_xy) * PROD_W'(corner.y1);
        prod_cx[0] = PROD_W'(mat.coef_yx) * PROD_W'(corner.x0);
        prod_cx[1] = PROD_W'(mat.coef_yx) * PROD_W'(corner.x1);
        prod_dy[0] = PROD_W'(mat.coef_yy) * PROD_W'(corner.y0);
        prod_dy[1] = PROD_W'(mat.coef_yy) * PROD_W'(corner.y1);
    end

    // register products with the fraction dropped (floor shift)
    always_ff @(posedge aclk) begin
        if (pipe_en.mult) begin
            for (int i = 0; i < 2; i++) begin
                ax_reg[i] <= prod_ax[i][PROD_W-1:FRAC_BITS];
                by_reg[i] <= prod_by[i][PROD_W-1:FRAC_BITS];
                cx_reg[i] <= prod_cx[i][PROD_W-1:FRAC_BITS];
                dy_reg[i] <= prod_dy[i][PROD_W-1:FRAC_BITS];
            end
            clip1_reg <= corner.clip;
        end
    end

    // corner i uses x edge i/2 and y edge i%2
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sum_px[i] = SUM_W'(ax_reg[i/2]) + SUM_W'(by_reg[i%2]) + SUM_W'(mat.offset_x);
            sum_py[i] = SUM_W'(cx_reg[i/2]) + SUM_W'(dy_reg[i%2]) + SUM_W'(mat.offset_y);
            ovf_px[i] = sat_flag(sum_px[i]);
            ovf_py[i] = sat_flag(sum_py[i]);
            mapped_next.px[i] = sat_coord(sum_px[i]);
            mapped_next.py[i] = sat_coord(sum_py[i]);
        end
        mapped_next.clip = clip1_reg | (|ovf_px) | (|ovf_py);
    end

    always_ff @(posedge aclk) begin
        if (pipe_en.sum) begin
            mapped_reg <= mapped_next;
        end
    end

    assign mapped = mapped_reg;

endmodule

### hw/rtl/arbb_extent.sv
// stages four and five: min/max of the mapped corners, then spans
`timescale 1ns / 1ps

module arbb_extent
    import arbb_pkg::*;
(
    input  logic              aclk,
    input  pipe_en_t          pipe_en,
    input  mapped_t           mapped,
    output coord_t            box_x,
    output coord_t            box_y,
    output logic [SPAN_W-1:0] box_w,
    output logic [SPAN_W-1:0] box_h,
    output logic              clipped
);

    coord_t                  min_x_next, max_x_next, min_y_next, max_y_next;
    coord_t                  min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic                    clip4_reg;
    logic signed [COORD_W:0] span_x;
    logic signed [COORD_W:0] span_y;
    logic                    ovf_w;
    logic                    ovf_h;
    coord_t                  box_x_reg, box_y_reg;
    logic [SPAN_W-1:0]       box_w_reg, box_h_reg;
    logic                    clipped_reg;

    function automatic coord_t min2(input coord_t a, input coord_t b);
        min2 = ($signed(a) < $signed(b)) ? a : b;
    endfunction

    function automatic coord_t max2(input coord_t a, input coord_t b);
        max2 = ($signed(a) > $signed(b)) ? a : b;
    endfunction

    // two-level compare tree over the four corners
    always_comb begin
        min_x_next = min2(min2(mapped.px[0], mapped.px[1]), min2(mapped.px[2], mapped.px[3]));
        max_x_next = max2(max2(mapped.px[0], mapped.px[1]), max2(mapped.px[2], mapped.px[3]));
        min_y_next = min2(min2(mapped.py[0], mapped.py[1]), min2(mapped.py[2], mapped.py[3]));
        max_y_next = max2(max2(mapped.py[0], mapped.py[1]), max2(mapped.py[2], mapped.py[3]));
    end

    always_ff @(posedge aclk) begin
        if (pipe_en.minmax) begin
            min_x_reg <= min_x_next;
            max_x_reg <= max_x_next;
            min_y_reg <= min_y_next;
            max_y_reg <= max_y_next;
            clip4_reg <= mapped.clip;
        end
    end

    // spans are never negative; anything at or above 2^31 saturates
    assign span_x = (COORD_W+1)'(max_x_reg) - (COORD_W+1)'(min_x_reg);
    assign span_y = (COORD_W+1)'(max_y_reg) - (COORD_W+1)'(min_y_reg);
    assign ovf_w  = |span_x[COORD_W:SPAN_W];
    assign ovf_h  = |span_y[COORD_W:SPAN_W];

    // output register
    always_ff @(posedge aclk) begin
        if (pipe_en.span) begin
            box_x_reg   <= min_x_reg;
            box_y_reg   <= min_y_reg;
            box_w_reg   <= ovf_w ? {SPAN_W{1'b1}} : span_x[SPAN_W-1:0];
            box_h_reg   <= ovf_h ? {SPAN_W{1'b1}} : span_y[SPAN_W-1:0];
            clipped_reg <= clip4_reg | ovf_w | ovf_h;
        end
    end

    assign box_x   = box_x_reg;
    assign box_y   = box_y_reg;
    assign box_w   = box_w_reg;
    assign box_h   = box_h_reg;
    assign clipped = clipped_reg;

endmodule

### hw/rtl/affine_rect_bounding_box.sv
// top level: affine bounding box of rectangles, five-stage pipeline
//
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      s_rect_x, s_rect_y, s_rect_w, s_rect_h
//  m_        out        m_valid / m_ready      m_box_x, m_box_y, m_box_w, m_box_h, m_clipped
//  cfg_      in         cfg_we (no wait)       cfg_index, cfg_data
//
//  one item per cycle while m_ready is high; m_valid marks an item in the output register
//  stages: corner sum, multipliers, mapped sums, min/max tree, span and output register
//  each stage has its own valid bit; a stage loads when empty or when the next one loads,
//  so a stall on m_ready fills bubbles first and loses or repeats nothing
//  synchronous active-low reset empties the pipeline and loads the identity matrix
`timescale 1ns / 1ps

module affine_rect_bounding_box
    import arbb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    // rectangles in
    input  logic              s_valid,
    output logic              s_ready,
    input  coord_t            s_rect_x,
    input  coord_t            s_rect_y,
    input  coord_t            s_rect_w,
    input  coord_t            s_rect_h,
    // boxes out
    output logic              m_valid,
    input  logic              m_ready,
    output coord_t            m_box_x,
    output coord_t            m_box_y,
    output logic [SPAN_W-1:0] m_box_w,
    output logic [SPAN_W-1:0] m_box_h,
    output logic              m_clipped
);

    localparam int STAGES = 5;

    affine_t             mat_reg;
    logic [STAGES-1:0]   valid_reg;
    logic [STAGES-1:0]   valid_next;
    logic [STAGES-1:0]   load;
    pipe_en_t            pipe_en;
    corner_t             corner;
    mapped_t             mapped;

    // matrix registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_reg.coef_xx  <= COEF_ONE;
            mat_reg.coef_xy  <= COEF_ZERO;
            mat_reg.offset_x <= COEF_ZERO;
            mat_reg.coef_yx  <= COEF_ZERO;
            mat_reg.coef_yy  <= COEF_ONE;
            mat_reg.offset_y <= COEF_ZERO;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_COEF_XX:  mat_reg.coef_xx  <= cfg_data;
                REG_COEF_XY:  mat_reg.coef_xy  <= cfg_data;
                REG_OFFSET_X: mat_reg.offset_x <= cfg_data;
                REG_COEF_YX:  mat_reg.coef_yx  <= cfg_data;
                REG_COEF_YY:  mat_reg.coef_yy  <= cfg_data;
                REG_OFFSET_Y: mat_reg.offset_y <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // stage load chain, from the output back to the input
    always_comb begin
        load[STAGES-1] = !valid_reg[STAGES-1] || m_ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            load[i] = !valid_reg[i] || load[i+1];
        end
        valid_next[0] = load[0] ? s_valid : valid_reg[0];
        for (int i = 1; i < STAGES; i++) begin
            valid_next[i] = load[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    assign pipe_en.corner = load[0];
    assign pipe_en.mult   = load[1];
    assign pipe_en.sum    = load[2];
    assign pipe_en.minmax = load[3];
    assign pipe_en.span   = load[4];

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = load[0];
    assign m_valid = valid_reg[STAGES-1];

    arbb_corner u_corner (
        .aclk    (aclk),
        .pipe_en (pipe_en),
        .rect_x  (s_rect_x),
        .rect_y  (s_rect_y),
        .rect_w  (s_rect_w),
        .rect_h  (s_rect_h),
        .corner  (corner)
    );

    arbb_map u_map (
        .aclk    (aclk),
        .pipe_en (pipe_en),
        .mat     (mat_reg),
        .corner  (corner),
        .mapped  (mapped)
    );

    arbb_extent u_extent (
        .aclk    (aclk),
        .pipe_en (pipe_en),
        .mapped  (mapped),
        .box_x   (m_box_x),
        .box_y   (m_box_y),
        .box_w   (m_box_w),
        .box_h   (m_box_h),
        .clipped (m_clipped)
    );

endmodule

### tb/sv/tb.sv
// self-checking testbench for the affine rectangle bounding box block
`timescale 1ns / 1ps

module tb;
    import arbb_pkg::*;

    // register indexes past the matrix, writes there must be ignored
    localparam logic [2:0] IDX_SPARE_A = 3'd6;
    localparam logic [2:0] IDX_SPARE_B = 3'd7;

    localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
    localparam coord_t COORD_MIN = 32'sh8000_0000;
    localparam longint S32_HI    = 64'sd2147483647;
    localparam longint S32_LO    = -64'sd2147483648;
    localparam int     PHASES    = 9;
    localparam int     PHASE_LEN = 100;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t w;
        coord_t h;
    } rect_item_t;

    typedef struct {
        coord_t            x;
        coord_t            y;
        logic [SPAN_W-1:0] w;
        logic [SPAN_W-1:0] h;
        logic              clipped;
    } box_item_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [2:0]        cfg_index = '0;
    logic [31:0]       cfg_data  = '0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    coord_t            s_rect_x  = '0;
    coord_t            s_rect_y  = '0;
    coord_t            s_rect_w  = '0;
    coord_t            s_rect_h  = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    coord_t            m_box_x;
    coord_t            m_box_y;
    logic [SPAN_W-1:0] m_box_w;
    logic [SPAN_W-1:0] m_box_h;
    logic              m_clipped;

    affine_t     matrix;
    rect_item_t  pending_rects[$];
    box_item_t   expected_boxes[$];
    rect_item_t  rect_on_bus;
    box_item_t   oldest_box;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int          errors      = 0;
    int          rects_sent  = 0;
    int          boxes_seen  = 0;
    int          boxes_sat   = 0;
    int          settings    = 1;

    affine_rect_bounding_box dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rect_x  (s_rect_x),
        .s_rect_y  (s_rect_y),
        .s_rect_w  (s_rect_w),
        .s_rect_h  (s_rect_h),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_box_x   (m_box_x),
        .m_box_y   (m_box_y),
        .m_box_w   (m_box_w),
        .m_box_h   (m_box_h),
        .m_clipped (m_clipped)
    );

    always #5 aclk = ~aclk;

    // clamp to the signed 32-bit range, flag saturation
    function automatic longint clamp_coord(input longint v, inout logic clip);
        if (v > S32_HI) begin
            clip = 1'b1;
            return S32_HI;
        end
        if (v < S32_LO) begin
            clip = 1'b1;
            return S32_LO;
        end
        return v;
    endfunction

    // one output coordinate of a corner, products floored by the arithmetic shift
    function automatic longint map_point(input coord_t ca, input coord_t cb,
                                         input coord_t off, input longint px,
                                         input longint py, inout logic clip);
        longint acc;
        acc = ((longint'(ca) * px) >>> FRAC_BITS) + ((longint'(cb) * py) >>> FRAC_BITS)
              + longint'(off);
        return clamp_coord(acc, clip);
    endfunction

    // bounding box of the four mapped corners under the current matrix
    function automatic box_item_t predict_box(input rect_item_t r);
        logic      clip;
        longint    x0, y0, x1, y1, cx, cy, px, py;
        longint    min_x, max_x, min_y, max_y, span_x, span_y;
        box_item_t b;
        clip = 1'b0;
        x0 = longint'(r.x);
        y0 = longint'(r.y);
        x1 = clamp_coord(x0 + longint'(r.w), clip);
        y1 = clamp_coord(y0 + longint'(r.h), clip);
        min_x = 0; max_x = 0; min_y = 0; max_y = 0;
        for (int i = 0; i < 4; i++) begin
            cx = i[1] ? x1 : x0;
            cy = i[0] ? y1 : y0;
            px = map_point(matrix.coef_xx, matrix.coef_xy, matrix.offset_x, cx, cy, clip);
            py = map_point(matrix.coef_yx, matrix.coef_yy, matrix.offset_y, cx, cy, clip);
            if (i == 0 || px < min_x) min_x = px;
            if (i == 0 || px > max_x) max_x = px;
            if (i == 0 || py < min_y) min_y = py;
            if (i == 0 || py > max_y) max_y = py;
        end
        span_x = max_x - min_x;
        span_y = max_y - min_y;
        if (span_x > S32_HI) begin
            span_x = S32_HI;
            clip = 1'b1;
        end
        if (span_y > S32_HI) begin
            span_y = S32_HI;
            clip = 1'b1;
        end
        b.x       = coord_t'(min_x);
        b.y       = coord_t'(min_y);
        b.w       = SPAN_W'(span_x);
        b.h       = SPAN_W'(span_y);
        b.clipped = clip;
        return b;
    endfunction

    // uniform value in [-half, half-1]
    function automatic coord_t spread(input int unsigned half);
        return coord_t'($urandom_range(2 * half - 1, 0)) - coord_t'(half);
    endfunction

    function automatic coord_t pick_edge();
        case ($urandom_range(4))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return -32'sd1;
            default: return COEF_ONE;
        endcase
    endfunction

    // half moderate rectangles, the rest points, noise, edge values and small random-placed ones
    function automatic rect_item_t random_rect();
        rect_item_t r;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
                r.x = spread(32'h0400_0000);
                r.y = spread(32'h0400_0000);
                r.w = spread(32'h0100_0000);
                r.h = spread(32'h0100_0000);
            end
            5: begin
                r.x = spread(32'h0400_0000);
                r.y = spread(32'h0400_0000);
                r.w = '0;
                r.h = '0;
            end
            6, 7: begin
                r.x = $urandom;
                r.y = $urandom;
                r.w = $urandom;
                r.h = $urandom;
            end
            8: begin
                r.x = pick_edge();
                r.y = pick_edge();
                r.w = pick_edge();
                r.h = pick_edge();
            end
            default: begin
                r.x = $urandom;
                r.y = $urandom;
                r.w = spread(256);
                r.h = spread(256);
            end
        endcase
        return r;
    endfunction

    // matrix for each random phase, extremes on a few of them
    function automatic affine_t phase_matrix(input int ph);
        affine_t m;
        case (ph)
            1: m = '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX};
            4: m = '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN};
            5: m = '{pick_edge(), pick_edge(), pick_edge(), pick_edge(), pick_edge(),
                     pick_edge()};
            7: m = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            default: m = '{spread(32'h0004_0000), spread(32'h0004_0000),
                           spread(32'h0400_0000), spread(32'h0004_0000),
                           spread(32'h0004_0000), spread(32'h0400_0000)};
        endcase
        return m;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_COEF_XX:  matrix.coef_xx  = data;
            REG_COEF_XY:  matrix.coef_xy  = data;
            REG_OFFSET_X: matrix.offset_x = data;
            REG_COEF_YX:  matrix.coef_yx  = data;
            REG_COEF_YY:  matrix.coef_yy  = data;
            REG_OFFSET_Y: matrix.offset_y = data;
            default: ;
        endcase
    endtask

    // full matrix load, spare indexes get junk that must not land anywhere
    task automatic load_matrix(input affine_t m);
        write_reg(REG_COEF_XX, m.coef_xx);
        write_reg(IDX_SPARE_A, $urandom);
        write_reg(REG_COEF_XY, m.coef_xy);
        write_reg(REG_OFFSET_X, m.offset_x);
        write_reg(REG_COEF_YX, m.coef_yx);
        write_reg(IDX_SPARE_B, $urandom);
        write_reg(REG_COEF_YY, m.coef_yy);
        write_reg(REG_OFFSET_Y, m.offset_y);
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic push_rect(input coord_t x, input coord_t y, input coord_t w,
                             input coord_t h);
        pending_rects.push_back('{x, y, w, h});
    endtask

    // waits until every rectangle is sent and every box is back, then lets the pipeline settle
    task automatic drain();
        @(negedge aclk);
        while (pending_rects.size() != 0 || s_valid || expected_boxes.size() != 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (errors < 40)
                $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
            errors++;
        end
    endtask

    // driver: records the prediction on accept, then offers the next rectangle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_boxes.push_back(predict_box(rect_on_bus));
                if (expected_boxes[$].clipped) boxes_sat++;
                rects_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_rects.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    rect_on_bus = pending_rects.pop_front();
                    s_valid  <= 1'b1;
                    s_rect_x <= rect_on_bus.x;
                    s_rect_y <= rect_on_bus.y;
                    s_rect_w <= rect_on_bus.w;
                    s_rect_h <= rect_on_bus.h;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each accepted box with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_boxes.size() == 0) begin
                    $display("%0t: unexpected box, expected none, got %h %h %h %h %b", $time,
                             m_box_x, m_box_y, m_box_w, m_box_h, m_clipped);
                    errors++;
                end else begin
                    oldest_box = expected_boxes.pop_front();
                    check_field("box_x", oldest_box.x, m_box_x);
                    check_field("box_y", oldest_box.y, m_box_y);
                    check_field("box_w", oldest_box.w, m_box_w);
                    check_field("box_h", oldest_box.h, m_box_h);
                    check_field("clipped", oldest_box.clipped, m_clipped);
                end
                boxes_seen++;
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // stimulus sequence
    initial begin
        matrix = '{COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE, COEF_ZERO};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 7;
        rx_idle_pct = 48;

        // reset matrix: points, negative sizes, corner and span saturation
        push_rect('0, '0, '0, '0);
        push_rect(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000);
        push_rect(32'sh0005_0000, 32'sh0005_0000, -32'sh0003_0000, -32'sh0002_0000);
        push_rect(COORD_MAX, COORD_MAX, '0, '0);
        push_rect(COORD_MIN, COORD_MIN, '0, '0);
        push_rect(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        push_rect(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        push_rect(COORD_MAX, '0, COORD_MIN, '0);
        push_rect('0, COORD_MAX, '0, COORD_MIN);
        push_rect(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        push_rect(-32'sd1, -32'sd1, 32'sd1, 32'sd1);
        push_rect('0, '0, -32'sd1, -32'sd1);
        drain();

        // mirrored half-weight matrix: floor rounding and mapped saturation
        load_matrix('{32'shFFFF_0000, 32'sh0000_8000, COORD_MAX,
                      32'sh0000_8000, 32'shFFFF_0000, COORD_MIN});
        push_rect(-32'sd1, -32'sd1, '0, '0);
        push_rect(32'sd1, 32'sd1, '0, '0);
        push_rect(32'sd3, -32'sd3, 32'sd2, -32'sd2);
        push_rect(COORD_MIN, '0, '0, '0);
        push_rect('0, COORD_MAX, '0, '0);
        push_rect(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        drain();

        // random phases, idle profile changes every third phase
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph / 3)
                0: begin
                    tx_idle_pct = 7;
                    rx_idle_pct = 48;
                end
                1: begin
                    tx_idle_pct = 48;
                    rx_idle_pct = 7;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            load_matrix(phase_matrix(ph));
            repeat (PHASE_LEN) pending_rects.push_back(random_rect());
            drain();
        end

        $display("checked %0d boxes for %0d rectangles under %0d matrix settings",
                 boxes_seen, rects_sent, settings);
        $display("%0d of the predicted boxes were saturated", boxes_sat);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
hw/rtl/arbb_pkg.sv
hw/rtl/arbb_corner.sv
hw/rtl/arbb_map.sv
hw/rtl/arbb_extent.sv
hw/rtl/affine_rect_bounding_box.sv
tb/sv/tb.sv
